// ----- design/heap_sort_engine_top_macros.svh -----
// Assertion helpers for the heap sort engine. They use the clock i_clk and
// reset i_rst_n, which must exist in the module where they are expanded.
`ifndef HEAP_SORT_ENGINE_TOP_MACROS_SVH
`define HEAP_SORT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hse_pkg.sv -----
package hse_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word value;
        logic  is_final;
    } t_in_item;

    typedef struct packed {
        t_word sorted_value;
        logic  is_final_res;
        logic  overflowed;
    } t_out_item;

endpackage

// ----- design/hse_stream_if.sv -----
interface hse_stream_if #(
    parameter type T = logic [31:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/heap_sort_engine_top.sv -----
// Heap sort engine.
// The input channel i_in carries one unsigned 32-bit value per request plus
// an is_final flag. Values are written into an internal store of CAPACITY
// entries, one request per cycle; requests beyond CAPACITY are dropped and
// flagged. The request marked final closes the run and starts the sort.
// The sort is a heap sort run by a small sequencer around one dual-read,
// single-write memory and one compare unit: a heap is built by sifting down
// from the middle position, then the root is moved to the last leaf and the
// heap is sifted again, N-1 times. Each sift level reads the children, then
// compares and moves. While sorting and emitting, i_in is not ready.
// The output channel o_out then returns the N values in ascending order,
// each read from the store and loaded into the output register, the next
// only after the last is taken; is_final_res marks the largest value and
// overflowed is set on every result of a run that dropped input. A stalled
// receiver simply holds the output register; the engine waits. The next run
// is accepted the cycle after the final result is taken. Reset (synchronous,
// active low) empties the store count, clears the overflow flag and any
// pending result.
module heap_sort_engine_top
    import hse_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hse_stream_if.sink   i_in,
    hse_stream_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD_TOP = 4'd1;
    localparam logic [3:0] S_TOP_WAIT = 4'd2;
    localparam logic [3:0] S_SIFT     = 4'd3;
    localparam logic [3:0] S_CMP      = 4'd4;
    localparam logic [3:0] S_EX_RD    = 4'd5;
    localparam logic [3:0] S_EX_WAIT  = 4'd6;
    localparam logic [3:0] S_OUT_RD   = 4'd7;
    localparam logic [3:0] S_OUT_LD   = 4'd8;
    localparam logic [3:0] S_OUT_HOLD = 4'd9;

    // Element store.
    t_word mem [CAPACITY];
    t_word r_rd_a;
    t_word r_rd_b;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_word         mem_wd;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] ra_b;

    // Control state.
    logic [3:0]    r_state,     n_state;
    logic [CW-1:0] r_count,     n_count;
    logic          r_ovf,       n_ovf;
    logic [CW-1:0] r_n,         n_n;
    logic [CW-1:0] r_top,       n_top;
    logic [CW-1:0] r_leaf,      n_leaf;
    logic [CW-1:0] r_node,      n_node;
    logic [CW-1:0] r_size,      n_size;
    logic          r_build,     n_build;
    logic [CW-1:0] r_k,         n_k;
    t_word         r_val,       n_val;
    t_out_item     r_out,       n_out;
    logic          r_out_valid, n_out_valid;

    logic [CW:0]   twice;
    logic [CW:0]   right;
    logic          use_right;
    logic [CW:0]   kid;
    t_word         kid_val;
    logic [CW-1:0] cnt_new;
    logic          sift_done;
    logic          in_fire;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Child positions of the current node (1-based heap positions).
    assign twice     = {r_node, 1'b0};
    assign right     = twice + (CW+1)'(1);
    assign use_right = (right <= {1'b0, r_size}) && (r_rd_b > r_rd_a);
    assign kid       = use_right ? right : twice;
    assign kid_val   = use_right ? r_rd_b : r_rd_a;
    assign cnt_new   = (r_count < CAP_C) ? (r_count + ONE) : r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_top       = r_top;
        n_leaf      = r_leaf;
        n_node      = r_node;
        n_size      = r_size;
        n_build     = r_build;
        n_k         = r_k;
        n_val       = r_val;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_wd      = i_in.data.value;
        ra_a        = '0;
        ra_b        = '0;
        sift_done   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (r_count < CAP_C) begin
                        mem_we  = 1'b1;
                        n_count = cnt_new;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.data.is_final) begin
                        n_n   = cnt_new;
                        n_top = cnt_new >> 1;
                        n_k   = '0;
                        if ((cnt_new >> 1) != '0) begin
                            n_build = 1'b1;
                            n_state = S_LOAD_TOP;
                        end else begin
                            n_state = S_OUT_RD;
                        end
                    end
                end
            end
            S_LOAD_TOP: begin
                ra_a    = AW'(r_top - ONE);
                n_state = S_TOP_WAIT;
            end
            S_TOP_WAIT: begin
                n_val   = r_rd_a;
                n_node  = r_top;
                n_size  = r_n;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                if (twice <= {1'b0, r_size}) begin
                    ra_a    = AW'(twice - (CW+1)'(1));
                    ra_b    = AW'(twice);
                    n_state = S_CMP;
                end else begin
                    mem_we    = 1'b1;
                    mem_wa    = AW'(r_node - ONE);
                    mem_wd    = r_val;
                    sift_done = 1'b1;
                end
            end
            S_CMP: begin
                // The sifted value lives in r_val; the hole moves down.
                mem_we = 1'b1;
                mem_wa = AW'(r_node - ONE);
                if (r_val < kid_val) begin
                    mem_wd  = kid_val;
                    n_node  = CW'(kid);
                    n_state = S_SIFT;
                end else begin
                    mem_wd    = r_val;
                    sift_done = 1'b1;
                end
            end
            S_EX_RD: begin
                ra_a    = '0;
                ra_b    = AW'(r_leaf - ONE);
                n_state = S_EX_WAIT;
            end
            S_EX_WAIT: begin
                // The root goes to its final place at the leaf.
                mem_we  = 1'b1;
                mem_wa  = AW'(r_leaf - ONE);
                mem_wd  = r_rd_a;
                n_val   = r_rd_b;
                n_node  = ONE;
                n_size  = r_leaf - ONE;
                n_state = S_SIFT;
            end
            S_OUT_RD: begin
                ra_a    = AW'(r_k);
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out.sorted_value = r_rd_a;
                n_out.is_final_res = (r_k == (r_n - ONE));
                n_out.overflowed   = r_ovf;
                n_out_valid        = 1'b1;
                n_state            = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.is_final_res) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + ONE;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Pick the next sift, or start the output, once the current sift has settled its value.
        if (sift_done) begin
            n_k = '0;
            if (r_build) begin
                if (r_top > ONE) begin
                    n_top   = r_top - ONE;
                    n_state = S_LOAD_TOP;
                end else begin
                    n_build = 1'b0;
                    n_leaf  = r_n;
                    n_state = (r_n > ONE) ? S_EX_RD : S_OUT_RD;
                end
            end else begin
                n_leaf  = r_leaf - ONE;
                n_state = ((r_leaf - ONE) > ONE) ? S_EX_RD : S_OUT_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= mem[ra_a];
        r_rd_b <= mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_build     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_build     <= n_build;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_top  <= n_top;
        r_leaf <= n_leaf;
        r_node <= n_node;
        r_size <= n_size;
        r_k    <= n_k;
        r_val  <= n_val;
        r_out  <= n_out;
    end

`include "heap_sort_engine_top_macros.svh"

    `HSE_ASSERT_IMP(a_out_in_hold, o_out.valid, r_state == S_OUT_HOLD, "result shown outside hold")
    `HSE_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CAP_C, "element count beyond capacity")
    `HSE_ASSERT_IMP(a_node_in_heap, r_state == S_SIFT, (r_node != '0) && (r_node <= r_size), "sift node outside heap")
    `HSE_ASSERT_NXT(a_final_to_idle, o_out.valid && o_out.ready && o_out.data.is_final_res, i_in.ready, "not ready after final result")

endmodule
